// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the leader marker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons on the same edge
`define BBLM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cond never holds
`define BBLM_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ----- rtl/bblm_pkg.sv -----
// ----------------------------------------------------------------------------
// bblm_pkg
// Types and constants shared by the leader marker front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package bblm_pkg;

  parameter int ADDRESS_SPACE_DEF = 4096;
  parameter int ENTRY_ADDRESS_DEF = 512;

  // marks stay below ENTRY + rom_length, which fits in 13 bits
  parameter int MARK_W = 13;
  // wide enough to compare a mark against the largest address space
  parameter int CMP_W = 17;
  parameter int QUEUE_DEPTH = 2;

  localparam logic FUNC_ANALYZE = 1'b0;
  localparam logic FUNC_QUERY   = 1'b1;

  // opcode groups (top nibble)
  localparam logic [3:0] OPG_SYS     = 4'h0;
  localparam logic [3:0] OPG_JP      = 4'h1;
  localparam logic [3:0] OPG_CALL    = 4'h2;
  localparam logic [3:0] OPG_SE_IMM  = 4'h3;
  localparam logic [3:0] OPG_SNE_IMM = 4'h4;
  localparam logic [3:0] OPG_SE_REG  = 4'h5;
  localparam logic [3:0] OPG_SNE_REG = 4'h9;
  localparam logic [3:0] OPG_JP_V0   = 4'hB;
  localparam logic [3:0] OPG_KEY     = 4'hE;

  localparam logic [15:0] OP_RET   = 16'h00EE;
  localparam logic [7:0]  KK_SKP   = 8'h9E;
  localparam logic [7:0]  KK_SKNP  = 8'hA1;

  // one classified word; for a query, tgt holds the queried address
  typedef struct packed {
    logic              query;
    logic              q_hit;
    logic              tgt_en;
    logic              nxt_en;
    logic              skp_en;
    logic [MARK_W-1:0] tgt;
    logic [MARK_W-1:0] nxt;
    logic [MARK_W-1:0] skp;
  } mark_req_t;

endpackage

`default_nettype wire

// ----- rtl/bblm_front.sv -----
// ----------------------------------------------------------------------------
// bblm_front
// Accepts input words, decodes the opcode and works out which marks to set.
// ----------------------------------------------------------------------------
`default_nettype none

module bblm_front import bblm_pkg::*; #(
  parameter int ADDRESS_SPACE = ADDRESS_SPACE_DEF,
  parameter int ENTRY_ADDRESS = ENTRY_ADDRESS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [11:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [11:0] address,
  input  wire logic [15:0] opcode,
  input  wire logic        q_full,
  input  wire logic        clearing,
  output logic             push,
  output mark_req_t        req
);

  localparam logic [CMP_W-1:0]  SPACE = CMP_W'(ADDRESS_SPACE);
  localparam logic [MARK_W-1:0] ENTRY = MARK_W'(ENTRY_ADDRESS);

  logic [11:0]       rom_length;
  logic [MARK_W-1:0] rom_end;
  logic [MARK_W-1:0] addr_m;
  logic [MARK_W-1:0] nnn_m;
  logic [MARK_W-1:0] addr_p2;
  logic [MARK_W-1:0] addr_p4;
  logic              is_query;
  logic              slot_ok;
  logic              tgt_ok;
  logic              has_tgt;
  logic              skip;
  logic              ends;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_length <= '0;
    end else if (cfg_write) begin
      rom_length <= cfg_data;
    end
  end

  assign in_stall = q_full | clearing;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    is_query = (func == FUNC_QUERY);
    rom_end  = ENTRY + {1'b0, rom_length};
    addr_m   = {1'b0, address};
    nnn_m    = {1'b0, opcode[11:0]};
    addr_p2  = addr_m + MARK_W'(2);
    addr_p4  = addr_m + MARK_W'(4);

    // instruction slot: at or past entry, even offset, whole word in ROM
    slot_ok = (addr_m >= ENTRY) && (address[0] == ENTRY[0]) &&
              ((addr_m + MARK_W'(1)) < rom_end);
    tgt_ok  = (nnn_m >= ENTRY) && ((nnn_m + MARK_W'(1)) < rom_end) && !opcode[0] &&
              (CMP_W'(nnn_m) < SPACE);

    has_tgt = 1'b0;
    skip    = 1'b0;
    ends    = 1'b0;
    unique case (opcode[15:12])
      OPG_SYS:     ends = (opcode == OP_RET);
      OPG_JP: begin
        has_tgt = 1'b1;
        ends    = 1'b1;
      end
      OPG_CALL:    has_tgt = 1'b1;
      OPG_SE_IMM,
      OPG_SNE_IMM: skip = 1'b1;
      OPG_SE_REG,
      OPG_SNE_REG: skip = (opcode[3:0] == 4'h0);
      OPG_JP_V0:   ends = 1'b1;
      OPG_KEY:     skip = (opcode[7:0] == KK_SKP) || (opcode[7:0] == KK_SKNP);
      default: begin
        has_tgt = 1'b0;
      end
    endcase

    req.query  = is_query;
    req.q_hit  = CMP_W'(addr_m) < SPACE;
    req.tgt    = is_query ? addr_m : nnn_m;
    req.nxt    = addr_p2;
    req.skp    = addr_p4;
    req.tgt_en = !is_query && slot_ok && has_tgt && tgt_ok;
    req.nxt_en = !is_query && slot_ok && (skip || ends) && (addr_p2 < rom_end) &&
                 (CMP_W'(addr_p2) < SPACE);
    req.skp_en = !is_query && slot_ok && skip && (addr_p4 < rom_end) &&
                 (CMP_W'(addr_p4) < SPACE);
  end

endmodule

`default_nettype wire

// ----- rtl/bblm_queue.sv -----
// ----------------------------------------------------------------------------
// bblm_queue
// Short FIFO of classified words between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bblm_queue import bblm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire mark_req_t  push_data,
  output logic            full,
  input  wire logic       pop,
  output mark_req_t       head,
  output logic            empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  mark_req_t       slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bblm_back.sv -----
// ----------------------------------------------------------------------------
// bblm_back
// Owns the leader bitmap: clears it after reset, sets marks one per cycle,
// reads leader bits and holds the result word until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bblm_back import bblm_pkg::*; #(
  parameter int ADDRESS_SPACE = ADDRESS_SPACE_DEF,
  parameter int ENTRY_ADDRESS = ENTRY_ADDRESS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_empty,
  input  wire mark_req_t  q_head,
  output logic            pop,
  output logic            clearing,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            is_leader,
  output logic            target_marked,
  output logic            next_marked,
  output logic            skip_marked
);

  localparam int            AW        = $clog2(ADDRESS_SPACE);
  localparam logic [AW-1:0] ENTRY_IDX = AW'(ENTRY_ADDRESS);
  localparam logic [AW-1:0] LAST_IDX  = AW'(ADDRESS_SPACE - 1);
  localparam logic          ENTRY_IN  = (ENTRY_ADDRESS < ADDRESS_SPACE);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WORK  = 5'b00100,
    ST_READ  = 5'b01000,
    ST_EMIT  = 5'b10000
  } back_state_t;

  back_state_t   state;
  back_state_t   state_next;
  logic [AW-1:0] clr_idx;
  mark_req_t     cur;
  logic [2:0]    pending;
  logic [2:0]    pending_next;
  logic [2:0]    sel;
  logic          load_out;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic          mem_wdata;
  logic          rd_bit;
  logic          leader_map [ADDRESS_SPACE];

  assign clearing = (state == ST_CLEAR);

  always_comb begin
    state_next   = state;
    pending_next = pending;
    sel          = '0;
    pop          = 1'b0;
    load_out     = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = AW'(cur.tgt);
    mem_wdata    = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_idx;
        mem_wdata = ENTRY_IN && (clr_idx == ENTRY_IDX);
        if (clr_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (q_head.query) begin
            state_next = ST_READ;
          end else if (q_head.tgt_en || q_head.nxt_en || q_head.skp_en) begin
            state_next = ST_WORK;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_WORK: begin
        // one bitmap write per cycle: target, then pc+2, then pc+4
        mem_we = 1'b1;
        priority if (pending[0]) begin
          sel      = 3'b001;
          mem_addr = AW'(cur.tgt);
        end else if (pending[1]) begin
          sel      = 3'b010;
          mem_addr = AW'(cur.nxt);
        end else begin
          sel      = 3'b100;
          mem_addr = AW'(cur.skp);
        end
        pending_next = pending & ~sel;
        if (pending_next == '0) begin
          state_next = ST_EMIT;
        end
      end
      ST_READ: begin
        mem_addr   = AW'(cur.tgt);
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= q_head;
      pending <= {q_head.skp_en, q_head.nxt_en, q_head.tgt_en};
    end else if (state == ST_WORK) begin
      pending <= pending_next;
    end
    if (load_out) begin
      is_leader     <= cur.query & cur.q_hit & rd_bit;
      target_marked <= cur.tgt_en;
      next_marked   <= cur.nxt_en;
      skip_marked   <= cur.skp_en;
    end
  end

  // single-port bitmap, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      leader_map[mem_addr] <= mem_wdata;
    end
    rd_bit <= leader_map[mem_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/basic_block_leader_marker.sv -----
// ----------------------------------------------------------------------------
// basic_block_leader_marker
// Marks basic-block leaders of CHIP-8 code in a one-bit-per-address bitmap.
// ----------------------------------------------------------------------------
// Input words (func, address, opcode) arrive on in_valid/in_stall; one result
// word (is_leader and the three mark flags) leaves on out_valid/out_stall for
// every input word, in order. func 0 analyzes the instruction at address and
// sets the leader marks it implies; func 1 reads the leader bit at address.
// rom_length is written through cfg_write/cfg_data; the user must write it
// only while the block is idle; the block itself does not enforce this.
// The back end owns one single-port bitmap: it pops a word in IDLE, writes
// its marks in WORK or reads the leader bit in READ, then loads the result
// in EMIT, and takes no new word until that result is loaded. A two-word
// queue lets the front keep accepting while the back is busy.
// After reset the bitmap is swept, one entry per cycle, and in_stall stays
// high until the sweep ends. rom_length resets to 0.
// When the receiver stalls, the result word holds and the back end waits
// with its next result; once the queue fills, in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module basic_block_leader_marker import bblm_pkg::*; #(
  parameter int ADDRESS_SPACE = ADDRESS_SPACE_DEF,
  parameter int ENTRY_ADDRESS = ENTRY_ADDRESS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [11:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [11:0] address,
  input  wire logic [15:0] opcode,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_leader,
  output logic             target_marked,
  output logic             next_marked,
  output logic             skip_marked
);

  mark_req_t req;
  mark_req_t q_head;
  logic      push;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  logic      clearing;

  bblm_front #(
    .ADDRESS_SPACE (ADDRESS_SPACE),
    .ENTRY_ADDRESS (ENTRY_ADDRESS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .address   (address),
    .opcode    (opcode),
    .q_full    (q_full),
    .clearing  (clearing),
    .push      (push),
    .req       (req)
  );

  bblm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (req),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  bblm_back #(
    .ADDRESS_SPACE (ADDRESS_SPACE),
    .ENTRY_ADDRESS (ENTRY_ADDRESS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .pop           (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_leader     (is_leader),
    .target_marked (target_marked),
    .next_marked   (next_marked),
    .skip_marked   (skip_marked)
  );

  `BBLM_ASSERT_NEVER(a_query_no_marks, clk, rst, out_valid && is_leader && (target_marked || next_marked || skip_marked), "leader bit reported with analyze marks")
  `BBLM_ASSERT_IMPLY(a_skip_has_next, clk, rst, out_valid && skip_marked, next_marked, "pc+4 marked without pc+2")
  `BBLM_ASSERT_IMPLY(a_quiet_while_clear, clk, rst, clearing, !out_valid && q_empty, "word in flight during bitmap sweep")

endmodule

`default_nettype wire

// ----- tb/tb_basic_block_leader_marker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_basic_block_leader_marker
// Self-checking bench for the CHIP-8 leader marker. A queue-fed driver sends
// analyze and query words, a scoreboard predicts the leader bitmap and the
// mark flags per word, and a monitor compares every result word in order.
// Several ROM lengths are swept, including zero, the full ROM and 4095.
// ----------------------------------------------------------------------------
module tb_basic_block_leader_marker;
  import bblm_pkg::*;

  localparam int ENTRY      = ENTRY_ADDRESS_DEF;
  localparam int MAP_SIZE   = ADDRESS_SPACE_DEF;
  localparam int HOLD_LEN   = 300;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        func;
    logic [11:0] address;
    logic [15:0] opcode;
  } insn_word_t;

  typedef struct packed {
    logic is_leader;
    logic target_marked;
    logic next_marked;
    logic skip_marked;
  } leader_flags_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = FUNC_ANALYZE;
  logic [11:0] address = '0;
  logic [15:0] opcode = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_leader;
  logic        target_marked;
  logic        next_marked;
  logic        skip_marked;

  insn_word_t    pending_words[$];
  leader_flags_t expected_flags[$];
  leader_flags_t want;

  bit          leader_bits[0:MAP_SIZE-1];
  int unsigned rom_bytes = 0;
  bit          offering = 1'b0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          idle_cycles = 0;
  int          fail_count = 0;

  basic_block_leader_marker i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .address       (address),
    .opcode        (opcode),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_leader     (is_leader),
    .target_marked (target_marked),
    .next_marked   (next_marked),
    .skip_marked   (skip_marked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- scoreboard

  function automatic bit set_leader(int a);
    if (a >= MAP_SIZE) return 1'b0;
    leader_bits[a] = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit target_in_rom(int t, int rom_end);
    return t >= ENTRY && t + 1 < rom_end && t[0] == 1'b0;
  endfunction

  function automatic leader_flags_t mark_leaders(insn_word_t w);
    leader_flags_t r;
    int rom_end;
    int pc;
    int nnn;
    bit skip_op;
    bit ends_op;
    r = '0;
    skip_op = 1'b0;
    ends_op = 1'b0;
    rom_end = ENTRY + int'(rom_bytes);
    pc = int'(w.address);
    nnn = int'(w.opcode[11:0]);
    if (w.func == FUNC_QUERY) begin
      r.is_leader = leader_bits[w.address];
      return r;
    end
    // not an instruction slot of the loaded ROM
    if (pc < ENTRY || ((pc - ENTRY) & 1) != 0 || pc + 1 >= rom_end) return r;
    case (w.opcode[15:12])
      OPG_SYS: ends_op = (w.opcode == OP_RET);
      OPG_JP: begin
        r.target_marked = target_in_rom(nnn, rom_end) && set_leader(nnn);
        ends_op = 1'b1;
      end
      OPG_CALL: r.target_marked = target_in_rom(nnn, rom_end) && set_leader(nnn);
      OPG_SE_IMM, OPG_SNE_IMM: skip_op = 1'b1;
      OPG_SE_REG, OPG_SNE_REG: skip_op = (w.opcode[3:0] == 4'h0);
      OPG_JP_V0: ends_op = 1'b1;
      OPG_KEY: skip_op = (w.opcode[7:0] == KK_SKP) || (w.opcode[7:0] == KK_SKNP);
      default: ;
    endcase
    if ((skip_op || ends_op) && pc + 2 < rom_end) r.next_marked = set_leader(pc + 2);
    if (skip_op && pc + 4 < rom_end) r.skip_marked = set_leader(pc + 4);
    return r;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_flags.push_back(mark_leaders(pending_words.pop_front()));
      offering = 1'b0;
    end
    @(negedge clk);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!offering) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
        in_valid <= 1'b1;
        func     <= pending_words[0].func;
        address  <= pending_words[0].address;
        opcode   <= pending_words[0].opcode;
        offering = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_flag(string name, logic exp_v, logic got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0b, got %0b", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_flags.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = expected_flags.pop_front();
        check_flag("is_leader", want.is_leader, is_leader);
        check_flag("target_marked", want.target_marked, target_marked);
        check_flag("next_marked", want.next_marked, next_marked);
        check_flag("skip_marked", want.skip_marked, skip_marked);
      end
    end
    @(negedge clk);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      // long hold-off so the internal queue fills and the input stalls
      hold_req = 1'b0;
      hold_left = HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 8);
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic add_word(logic f, logic [11:0] a, logic [15:0] op);
    insn_word_t w;
    w.func = f;
    w.address = a;
    w.opcode = op;
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || offering || expected_flags.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_rom(int unsigned len);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= len[11:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    rom_bytes = len;
  endtask

  // even slot inside the ROM, biased toward the last one; any address if the ROM is under one word
  function automatic logic [11:0] pick_slot();
    int last_k;
    int k;
    if (rom_bytes < 2) return 12'($urandom);
    last_k = (int'(rom_bytes) - 2) / 2;
    if (last_k > (MAP_SIZE - 2 - ENTRY) / 2) last_k = (MAP_SIZE - 2 - ENTRY) / 2;
    k = ($urandom_range(99) < 15) ? last_k : $urandom_range(last_k, 0);
    return 12'(ENTRY + 2 * k);
  endfunction

  function automatic logic [11:0] pick_target();
    if ($urandom_range(99) < 70) return pick_slot();
    return 12'($urandom);
  endfunction

  task automatic push_random(int n);
    logic [11:0] a;
    logic [15:0] op;
    int r;
    int hi;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      op = 16'($urandom);
      if (r < 15) begin
        hi = ENTRY + int'(rom_bytes) + 4;
        if (hi > MAP_SIZE - 1) hi = MAP_SIZE - 1;
        a = ($urandom_range(99) < 60) ? 12'($urandom_range(hi, ENTRY)) : 12'($urandom);
        add_word(FUNC_QUERY, a, op);
      end else if (r < 85) begin
        case ($urandom_range(8))
          0: op = {OPG_JP, pick_target()};
          1: op = {OPG_CALL, pick_target()};
          2: op = OP_RET;
          3: op = {OPG_SYS, op[11:0]};
          4: op = {($urandom_range(1) != 0) ? OPG_SE_IMM : OPG_SNE_IMM, op[11:0]};
          5: op = {($urandom_range(1) != 0) ? OPG_SE_REG : OPG_SNE_REG, op[11:4],
                   ($urandom_range(99) < 75) ? 4'h0 : op[3:0]};
          6: begin
            r = $urandom_range(99);
            op = {OPG_KEY, op[11:8], (r < 40) ? KK_SKP : (r < 80) ? KK_SKNP : op[7:0]};
          end
          7: op = {OPG_JP_V0, op[11:0]};
          default: ;
        endcase
        add_word(FUNC_ANALYZE, pick_slot(), op);
      end else begin
        add_word(FUNC_ANALYZE, 12'($urandom), op);
      end
    end
  endtask

  int phase_len[8] = '{200, 3584, 16, 4095, -1, 6, 1024, 0};
  int phase_cnt[8] = '{200, 230, 150, 200, 200, 100, 290, 50};

  initial begin
    int len;
    for (int i = 0; i < MAP_SIZE; i++) leader_bits[i] = 1'b0;
    leader_bits[ENTRY] = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset state: entry bit only, empty ROM ignores analyze words
    add_word(FUNC_QUERY, 12'(ENTRY), 16'h0000);
    add_word(FUNC_QUERY, 12'h000, 16'hFFFF);
    add_word(FUNC_QUERY, 12'hFFF, 16'h0000);
    add_word(FUNC_ANALYZE, 12'h200, {OPG_JP, 12'h204});
    wait_drained();

    set_rom(3584);
    add_word(FUNC_ANALYZE, 12'h1FE, {OPG_JP, 12'h300});   // below entry
    add_word(FUNC_ANALYZE, 12'h201, {OPG_JP, 12'h300});   // odd slot
    add_word(FUNC_ANALYZE, 12'h200, {OPG_JP, 12'h300});
    add_word(FUNC_ANALYZE, 12'h202, {OPG_JP, 12'h301});   // odd target
    add_word(FUNC_ANALYZE, 12'h204, {OPG_CALL, 12'h1FE}); // target below ROM
    add_word(FUNC_ANALYZE, 12'h206, {OPG_CALL, 12'hFFE});
    add_word(FUNC_ANALYZE, 12'h208, OP_RET);
    add_word(FUNC_ANALYZE, 12'h20A, {OPG_SYS, 12'h0E0});
    add_word(FUNC_ANALYZE, 12'h20C, {OPG_SE_IMM, 12'hA55});
    add_word(FUNC_ANALYZE, 12'h210, {OPG_SNE_IMM, 12'hBFF});
    add_word(FUNC_ANALYZE, 12'h214, {OPG_SE_REG, 12'h120});
    add_word(FUNC_ANALYZE, 12'h218, {OPG_SE_REG, 12'h121});
    add_word(FUNC_ANALYZE, 12'h21A, {OPG_SNE_REG, 12'h340});
    add_word(FUNC_ANALYZE, 12'h21E, {OPG_SNE_REG, 12'h341});
    add_word(FUNC_ANALYZE, 12'h220, {OPG_KEY, 4'h1, KK_SKP});
    add_word(FUNC_ANALYZE, 12'h224, {OPG_KEY, 4'h2, KK_SKNP});
    add_word(FUNC_ANALYZE, 12'h228, {OPG_KEY, 4'h3, 8'h00});
    add_word(FUNC_ANALYZE, 12'h22C, {OPG_JP_V0, 12'h123});
    add_word(FUNC_ANALYZE, 12'h230, 16'hFFFF);
    add_word(FUNC_ANALYZE, 12'hFFE, {OPG_SE_IMM, 12'h000}); // marks past ROM end
    add_word(FUNC_ANALYZE, 12'hFFC, {OPG_JP, 12'h200});
    add_word(FUNC_ANALYZE, 12'h200, {OPG_JP, 12'h300});     // marks already set
    add_word(FUNC_QUERY, 12'h300, 16'h0000);
    add_word(FUNC_QUERY, 12'hFFE, 16'h0000);
    wait_drained();

    // ROM end beyond the map: marks at the map edge are dropped
    set_rom(4095);
    add_word(FUNC_ANALYZE, 12'hFFC, {OPG_KEY, 4'h0, KK_SKP});
    add_word(FUNC_ANALYZE, 12'hFFE, {OPG_JP, 12'hFFE});
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      len = (phase_len[p] < 0) ? $urandom_range(3584) : phase_len[p];
      set_rom(len);
      calm = (p == 3);
      hold_req = (p == 1);
      if (p == 6) begin
        push_random(phase_cnt[p] / 2);
        wait_drained();
        push_random(phase_cnt[p] - phase_cnt[p] / 2);
      end else begin
        push_random(phase_cnt[p]);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_flags.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
